// ----- sv/fwmtpa_pkg.sv -----
// Package for the field-weakening / MTPA Id reference block.
// Holds payload structs, register indexes, constants and the MTPA tables.
// No dependencies.
package fwmtpa_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FW_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATED      = 2'd3;

	localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
	localparam logic [15:0] MARGIN_UNITS = 16'd150;
	localparam logic signed [31:0] INTEG_LIMIT = 32'sd65536000;
	localparam logic [15:0] DECAY_Q16 = 16'd65208;
	localparam logic [13:0] PU_ONE = 14'd10000;

	typedef struct packed {
		logic signed [15:0] iq_command;
		logic signed [15:0] volt_q;
		logic signed [15:0] volt_d;
		logic [15:0]        bus_voltage;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] id_command;
		logic signed [15:0] fw_current;
		logic               weaken_on;
	} out_item_t;

	localparam logic [15:0] MTPA_IQ [TABLE_ENTRIES] = '{
		16'd0, 16'd159, 16'd317, 16'd476, 16'd635, 16'd794, 16'd952, 16'd1111,
		16'd1270, 16'd1429, 16'd1587, 16'd1746, 16'd1905, 16'd2063, 16'd2222,
		16'd2381, 16'd2540, 16'd2698, 16'd2857, 16'd3016, 16'd3175, 16'd3333,
		16'd3492, 16'd3651, 16'd3810, 16'd3968, 16'd4127, 16'd4286, 16'd4444,
		16'd4603, 16'd4762, 16'd4921, 16'd5079, 16'd5238, 16'd5397, 16'd5556,
		16'd5714, 16'd5873, 16'd6032, 16'd6190, 16'd6349, 16'd6508, 16'd6667,
		16'd6825, 16'd6984, 16'd7143, 16'd7302, 16'd7460, 16'd7619, 16'd7778,
		16'd7937, 16'd8095, 16'd8254, 16'd8413, 16'd8571, 16'd8730, 16'd8889,
		16'd9048, 16'd9206, 16'd9365, 16'd9524, 16'd9683, 16'd9841, 16'd10000
	};

	localparam logic [15:0] MTPA_IDMAG [TABLE_ENTRIES] = '{
		16'd0, 16'd2, 16'd8, 16'd18, 16'd32, 16'd50, 16'd72, 16'd98, 16'd127,
		16'd161, 16'd198, 16'd240, 16'd285, 16'd335, 16'd389, 16'd448, 16'd511,
		16'd579, 16'd651, 16'd728, 16'd810, 16'd897, 16'd989, 16'd1087, 16'd1190,
		16'd1298, 16'd1413, 16'd1534, 16'd1661, 16'd1795, 16'd1936, 16'd2084,
		16'd2240, 16'd2404, 16'd2577, 16'd2758, 16'd2949, 16'd3149, 16'd3359,
		16'd3580, 16'd3812, 16'd4056, 16'd4312, 16'd4581, 16'd4863, 16'd5159,
		16'd5470, 16'd5797, 16'd6141, 16'd6503, 16'd6884, 16'd7285, 16'd7708,
		16'd8155, 16'd8627, 16'd9127, 16'd9657, 16'd10000, 16'd10000, 16'd10000,
		16'd10000, 16'd10000, 16'd10000, 16'd10000
	};

endpackage

// ----- sv/field_weakening_mtpa_id_reference_core.sv -----
// Top level of the field-weakening / MTPA Id reference block.
// Sequencer around one shared multiplier and a restoring divider.
// Depends on fwmtpa_pkg.
//
// channel | direction | handshake        | payload
// in      | input     | in_valid/ready   | in_item_t (Iq ref, Vq, Vd, Vbus)
// out     | output    | out_valid/ready  | out_item_t (Id ref, FW Id, active)
// cfg     | input     | cfg_we           | cfg_idx, cfg_data
//
// With weakening on, one item runs 17 square-root steps at two radicand bits
// each, a binary table search, 64 divider iterations and steps through the
// shared multiplier; with it off the square-root, PI and decay steps are
// skipped. Iq or rated current of zero skips the interpolation and divide.
// in_ready is high only in the idle state; a finished result waits in the
// output register until taken, and the next item is accepted meanwhile.
// Reset clears the control state and loads the register reset values.
module field_weakening_mtpa_id_reference_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  fwmtpa_pkg::in_item_t               in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output fwmtpa_pkg::out_item_t              out_data,
	input  logic                               cfg_we,
	input  logic [fwmtpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fwmtpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fwmtpa_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_SQ1, S_SQ2, S_SQRT, S_LIM, S_PI1, S_PI2, S_DEC,
		S_MT0, S_SRCH, S_INT1, S_INT2, S_INT3, S_INT4, S_INT5, S_DIV, S_DONE
	} state_t;

	state_t state_q;
	in_item_t in_q;
	logic fw_en_q;
	logic [15:0] kp_q, ki_q;
	logic [14:0] rated_q;
	logic signed [31:0] integ_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [33:0] acc_q;          // general accumulator / sqrt radicand
	logic [16:0] root_q;
	logic [33:0] rem_q;
	logic [5:0] cnt_q;
	logic signed [17:0] err_q;
	logic signed [16:0] fw_q;
	logic active_q;
	logic [IW-1:0] lo_q, hi_q;
	logic [30:0] a_q;            // |iq| * 10000
	logic [31:0] num_q, den_q;   // interpolation terms (den is per rated)
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [63:0] quo_q;
	logic signed [16:0] idm_q;

	// shared multiplier, 32x32 unsigned
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic [IW-1:0] mid;
	assign mid = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	logic [15:0] abs_iq;
	assign abs_iq = in_q.iq_command[15] ? 16'(-in_q.iq_command) : in_q.iq_command;
	logic [15:0] abs_vq, abs_vd;
	assign abs_vq = in_q.volt_q[15] ? 16'(-in_q.volt_q) : in_q.volt_q;
	assign abs_vd = in_q.volt_d[15] ? 16'(-in_q.volt_d) : in_q.volt_d;

	logic [15:0] tbl_iq_mid, tbl_iq_lo, tbl_iq_hi, tbl_id_lo, tbl_id_hi;
	assign tbl_iq_mid = MTPA_IQ[mid];
	assign tbl_iq_lo = MTPA_IQ[lo_q];
	assign tbl_iq_hi = MTPA_IQ[hi_q];
	assign tbl_id_lo = MTPA_IDMAG[lo_q];
	assign tbl_id_hi = MTPA_IDMAG[hi_q];

	logic [33:0] sq_try;
	logic [33:0] rem_sh;
	assign rem_sh = {rem_q[31:0], acc_q[33:32]};
	assign sq_try = {15'd0, root_q, 2'b01};

	logic [64:0] div_diff;
	assign div_diff = {dvd_q[63:0], quo_q[63]} - {1'b0, dvs_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ1: begin mul_a = {16'd0, abs_vq}; mul_b = {16'd0, abs_vq}; end
			S_SQ2: begin mul_a = {16'd0, abs_vd}; mul_b = {16'd0, abs_vd}; end
			S_LIM: begin mul_a = {16'd0, in_q.bus_voltage}; mul_b = {16'd0, INV_SQRT3_Q16}; end
			S_PI1: begin mul_a = {16'd0, ki_q}; mul_b = 32'(err_q); end
			S_PI2: begin mul_a = {16'd0, kp_q}; mul_b = 32'(err_q); end
			S_DEC: begin
				mul_a = integ_q[31] ? 32'(-integ_q) : integ_q;
				mul_b = {16'd0, DECAY_Q16};
			end
			S_MT0: begin mul_a = {16'd0, abs_iq}; mul_b = {18'd0, PU_ONE}; end
			S_SRCH: begin mul_a = {16'd0, tbl_iq_mid}; mul_b = {17'd0, rated_q}; end
			S_INT1: begin mul_a = {16'd0, tbl_iq_lo}; mul_b = {17'd0, rated_q}; end
			S_INT2: begin mul_a = {16'd0, tbl_id_hi - tbl_id_lo}; mul_b = num_q; end
			S_INT3: begin mul_a = {16'd0, tbl_id_lo}; mul_b = den_q; end
			S_INT4: begin mul_a = num_q; mul_b = {17'd0, rated_q}; end
			S_INT5: begin mul_a = den_q; mul_b = {18'd0, PU_ONE}; end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	logic signed [33:0] integ_sum;
	logic signed [33:0] integ_clamped;
	always_comb begin
		integ_sum = 34'(integ_q) + 34'(signed'(mul_p[33:0]));
		if (integ_sum > 34'(INTEG_LIMIT)) integ_clamped = 34'(INTEG_LIMIT);
		else if (integ_sum < -34'(INTEG_LIMIT)) integ_clamped = -34'(INTEG_LIMIT);
		else integ_clamped = integ_sum;
	end

	logic signed [34:0] total;
	assign total = 35'(signed'(mul_p[33:0])) + 35'(integ_q);

	logic signed [16:0] neg_rated;
	assign neg_rated = -17'(rated_q);

	logic signed [16:0] id_min;
	always_comb begin
		id_min = (idm_q < fw_q) ? idm_q : fw_q;
		if (id_min < neg_rated) id_min = neg_rated;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fw_en_q <= 1'b1;
			kp_q <= 16'd655;
			ki_q <= 16'd66;
			rated_q <= 15'd1000;
			integ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FW_ENABLE: begin
						fw_en_q <= cfg_data[0];
						if (!cfg_data[0]) integ_q <= '0;
					end
					REG_PROP_GAIN: kp_q <= cfg_data;
					REG_INTEG_GAIN: ki_q <= cfg_data;
					REG_RATED: rated_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					in_q <= in_data;
					fw_q <= '0;
					active_q <= 1'b0;
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					acc_q <= {2'b00, mul_p[31:0]};
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					acc_q <= acc_q + {2'b00, mul_p[31:0]};
					root_q <= '0;
					rem_q <= '0;
					cnt_q <= 6'd17;
					state_q <= fw_en_q ? S_SQRT : S_MT0;
					if (!fw_en_q) integ_q <= '0;
				end
				S_SQRT: begin
					// two radicand bits per cycle, restoring
					if (rem_sh >= sq_try) begin
						rem_q <= rem_sh - sq_try;
						root_q <= {root_q[15:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[15:0], 1'b0};
					end
					acc_q <= {acc_q[31:0], 2'b00};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= S_LIM;
				end
				S_LIM: begin
					err_q <= 18'(signed'({1'b0, root_q}))
						- (18'(mul_p[31:16]) - 18'(MARGIN_UNITS));
					state_q <= S_PI1;
				end
				S_PI1: begin
					if (err_q > 0) begin
						active_q <= 1'b1;
						integ_q <= integ_clamped[31:0];
						state_q <= S_PI2;
					end else begin
						state_q <= S_DEC;
					end
				end
				S_PI2: begin
					if (total < 0) fw_q <= '0;
					else if (total[34:16] > 19'(rated_q)) fw_q <= neg_rated;
					else fw_q <= -17'(total[32:16]);
					state_q <= S_MT0;
				end
				S_DEC: begin
					integ_q <= integ_q[31] ? -32'(mul_p[47:16]) : 32'(mul_p[47:16]);
					state_q <= S_MT0;
				end
				S_MT0: begin
					a_q <= mul_p[30:0];
					lo_q <= '0;
					hi_q <= LAST;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (rated_q == '0 || a_q == '0) begin
						idm_q <= '0;
						state_q <= S_DONE;
					end else if ({1'b0, a_q} >= 32'(MTPA_IQ[LAST]) * 32'(rated_q)) begin
						lo_q <= LAST;
						hi_q <= LAST;
						num_q <= '0;
						state_q <= S_INT1;
					end else if (hi_q - lo_q > IW'(1)) begin
						if (mul_p[31:0] <= {1'b0, a_q}) lo_q <= mid; else hi_q <= mid;
					end else begin
						state_q <= S_INT1;
					end
				end
				S_INT1: begin
					// saturated end: lo == hi, a unit span gives idlo * rated / 10000
					num_q <= {1'b0, a_q} - mul_p[31:0];
					den_q <= (tbl_iq_hi == tbl_iq_lo) ? 32'd1 : 32'(tbl_iq_hi - tbl_iq_lo);
					state_q <= S_INT2;
				end
				// id = (idlo*den + d*num) * rated / (den*10000); den scaled by rated
				// cancels one rated: q = (idlo*dIq*R + d*num)/(dIq*10000)
				S_INT2: begin
					dvd_q <= mul_p;
					state_q <= S_INT3;
				end
				S_INT3: begin
					num_q <= mul_p[31:0];
					state_q <= S_INT4;
				end
				S_INT4: begin
					dvd_q <= dvd_q + mul_p;
					state_q <= S_INT5;
				end
				S_INT5: begin
					dvs_q <= mul_p;
					quo_q <= dvd_q;
					dvd_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring, dividend shifted in from the top of quo_q
					if (!div_diff[64]) begin
						dvd_q <= div_diff[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						dvd_q <= {dvd_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						// quotient never exceeds rated current
						idm_q <= -17'({quo_q[14:0], ~div_diff[64]});
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.id_command <= id_min[15:0];
						out_q.fw_current <= fw_q[15:0];
						out_q.weaken_on <= active_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_fw_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.fw_current <= 16'sd0))
		else $error("fw_current sign");
	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted while busy");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	ap_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while waiting");
	ap_integ_lim: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= INTEG_LIMIT && integ_q >= -INTEG_LIMIT)
		else $error("integrator out of range");
endmodule
